/* src/rdel_pkg.sv */
`default_nettype none
package rdel_pkg;

	localparam int unsigned MAX_WORDS_DEF = 1024;
	localparam logic [11:0] MAX_NAME_LEN_RST = 12'd255;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_VF,
		PH_NAME,
		PH_BM,
		PH_ATTR,
		PH_EOF
	} phase_t;

	typedef enum logic [1:0] {
		VERDICT_COMPLETE,
		VERDICT_TRUNC,
		VERDICT_IOERR
	} verdict_t;

	typedef enum logic [1:0] {
		FIX_NONE,
		FIX_ZERO_TWO,
		FIX_SET_ONE
	} fixup_t;

	// walk state carried from one item to the next
	typedef struct packed {
		phase_t      phase;
		logic [9:0]  wpos;
		logic [10:0] rem;
		logic [10:0] skip;
		logic [10:0] entries;
		logic [9:0]  last_start;
	} rdel_state_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [10:0] count;
		logic [9:0]  offset;
		fixup_t      fixup;
	} rdel_result_t;

endpackage
`default_nettype wire

/* src/readdir_entry_list_checker_top.sv */
`default_nettype none
// Channel  Handshake            Payload
// in       in_valid / in_ready  data_word, first_word, total_words
// out      out_valid/out_ready  verdict, entry_count, entry_offset, fixup_kind
// cfg      cfg_we               cfg_wdata (max_name_len)
//
// One item per cycle while no finished result is stalled; out_valid rises once its item
// has passed the input register and the result register has loaded.
// The walk logic between the two registers is a handful of 32-bit compares.
// arst_n clears the walk state and both valid flags; max_name_len returns to 255.
// A stalled result stalls the input register only when the next item also
// finishes a walk; items that give no result keep flowing.
module readdir_entry_list_checker_top import rdel_pkg::*; #(
	parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] data_word,
	input  wire logic        first_word,
	input  wire logic [10:0] total_words,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       verdict,
	output logic [10:0]      entry_count,
	output logic [9:0]       entry_offset,
	output logic [1:0]       fixup_kind,
	input  wire logic        cfg_we,
	input  wire logic [11:0] cfg_wdata
);

	// input register
	logic        valid_s1;
	logic [31:0] data_word_s1;
	logic        first_word_s1;
	logic [10:0] total_words_s1;

	logic [11:0]  max_name_len_q;
	rdel_state_t  st_q;
	rdel_state_t  st_next;
	logic         res_valid;
	rdel_result_t res;
	rdel_result_t res_q;
	logic         out_valid_q;
	logic         s1_go;

	// advance the input register unless its result would land on a full slot
	assign s1_go    = valid_s1 && (!res_valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_len_q <= MAX_NAME_LEN_RST;
		end else if (cfg_we) begin
			max_name_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload: hold while stalled
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_word_s1   <= data_word;
			first_word_s1  <= first_word;
			total_words_s1 <= total_words;
		end
	end

	rdel_step #(
		.MAX_WORDS(MAX_WORDS)
	) u_step (
		.st          (st_q),
		.word        (data_word_s1),
		.first       (first_word_s1),
		.total       (total_words_s1),
		.max_name_len(max_name_len_q),
		.nst         (st_next),
		.res_valid   (res_valid),
		.res         (res)
	);

	// walk state: advance once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, default: '0};
		end else if (s1_go) begin
			st_q <= st_next;
		end
	end

	// result register: drop when taken, load when a walk finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign verdict      = res_q.verdict;
	assign entry_count  = res_q.count;
	assign entry_offset = res_q.offset;
	assign fixup_kind   = res_q.fixup;

`ifndef SYNTH
	// a finished or idle walk never leaves words to skip
	a_idle_no_skip: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_IDLE |-> st_q.skip == '0)
		else $error("idle walk with pending skip");

	// the empty-list wait is only reached before any entry and off a skip
	a_eof_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_EOF |-> (st_q.entries == '0 && st_q.skip == '0))
		else $error("EOF wait with entries or skip");

	// zeroing fixup only goes with a truncated list that kept entries
	a_fix_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fixup_kind == FIX_ZERO_TWO |->
			(verdict == VERDICT_TRUNC && entry_count != '0))
		else $error("zero fixup without kept entries");
`endif

endmodule
`default_nettype wire

/* src/rdel_step.sv */
`default_nettype none
module rdel_step import rdel_pkg::*; #(
	parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
) (
	input  var rdel_state_t  st,
	input  wire logic [31:0] word,
	input  wire logic        first,
	input  wire logic [10:0] total,
	input  wire logic [11:0] max_name_len,
	output var rdel_state_t  nst,
	output logic             res_valid,
	output var rdel_result_t res
);

	localparam logic [16:0] MaxW = 17'(MAX_WORDS);

	logic [10:0] tot;
	logic [32:0] pad_sum;
	logic [30:0] padw;
	logic [31:0] padw_p1;
	logic [31:0] rem_ext;
	logic        go;
	logic        fin;
	logic        past_end;
	verdict_t    fin_verdict;
	fixup_t      fin_fix;

	assign pad_sum = {1'b0, word} + 33'd3;
	assign padw    = pad_sum[32:2];
	assign padw_p1 = {1'b0, padw} + 32'd1;

	always_comb begin
		nst         = st;
		go          = 1'b0;
		fin         = 1'b0;
		past_end    = 1'b0;
		fin_verdict = VERDICT_COMPLETE;
		fin_fix     = FIX_NONE;
		tot         = ({6'b0, total} > MaxW) ? MaxW[10:0] : total;

		if (first) begin
			nst.wpos       = '0;
			nst.skip       = '0;
			nst.entries    = '0;
			nst.last_start = '0;
			if (tot < 11'd2) begin
				nst.rem     = '0;
				fin         = 1'b1;
				fin_verdict = VERDICT_IOERR;
			end else begin
				nst.rem   = tot - 11'd1;
				nst.phase = PH_VF;
				go        = 1'b1;
			end
		end else if (st.phase != PH_IDLE) begin
			nst.wpos = st.wpos + 10'd1;
			if (st.rem != '0)
				nst.rem = st.rem - 11'd1;
			go = 1'b1;
		end

		rem_ext = {21'b0, nst.rem};

		if (go) begin
			if (nst.phase != PH_EOF && nst.skip != '0) begin
				nst.skip = nst.skip - 11'd1;
			end else begin
				unique case (nst.phase)
					PH_VF: begin
						if (word == '0) begin
							if (nst.entries != '0)
								fin = 1'b1;
							else
								nst.phase = PH_EOF;
						end else if (nst.rem < 11'd3) begin
							past_end = 1'b1;
						end else begin
							nst.skip  = 11'd2;
							nst.phase = PH_NAME;
						end
					end
					PH_NAME: begin
						if (word > {20'b0, max_name_len}) begin
							fin         = 1'b1;
							fin_verdict = VERDICT_IOERR;
						end else if ({1'b0, padw} >= rem_ext) begin
							past_end = 1'b1;
						end else begin
							nst.skip  = padw[10:0];
							nst.phase = PH_BM;
						end
					end
					PH_BM: begin
						if (word >= rem_ext) begin
							past_end = 1'b1;
						end else begin
							nst.skip  = word[10:0];
							nst.phase = PH_ATTR;
						end
					end
					PH_ATTR: begin
						if (padw_p1 >= rem_ext) begin
							past_end = 1'b1;
						end else begin
							nst.entries    = nst.entries + 11'd1;
							nst.last_start = nst.wpos + 10'd1 + padw[9:0];
							nst.skip       = padw[10:0];
							nst.phase      = PH_VF;
						end
					end
					PH_EOF: begin
						fin     = 1'b1;
						fin_fix = (word == '0) ? FIX_SET_ONE : FIX_NONE;
					end
					default: ;
				endcase
			end
		end

		// a length past the end keeps what was accepted so far
		if (past_end) begin
			fin = 1'b1;
			if (nst.entries != '0) begin
				fin_verdict = VERDICT_TRUNC;
				fin_fix     = FIX_ZERO_TWO;
			end else begin
				fin_verdict = VERDICT_IOERR;
			end
		end

		if (fin)
			nst.phase = PH_IDLE;

		res_valid   = fin;
		res.verdict = fin_verdict;
		res.count   = nst.entries;
		res.offset  = nst.last_start;
		res.fixup   = fin_fix;
	end

endmodule
`default_nettype wire

/* test/readdir_entry_list_checker_top_tb.sv */
`timescale 1ns / 1ps
module readdir_entry_list_checker_top_tb import rdel_pkg::*; ();

	// Long receiver hold-off used to back the block up into its input.
	localparam int unsigned HOLD_CYCLES = 400;
	// Input register plus result register, with some margin.
	localparam int unsigned SETTLE_CYCLES = 4;

	// One reply word as it sits on the input channel.
	typedef struct {
		logic [31:0] data;
		logic        first;
		logic [10:0] total;
	} reply_word_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] data_word = '0;
	logic        first_word = 1'b0;
	logic [10:0] total_words = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  verdict;
	logic [10:0] entry_count;
	logic [9:0]  entry_offset;
	logic [1:0]  fixup_kind;
	logic        cfg_we = 1'b0;
	logic [11:0] cfg_wdata = '0;

	// Walk state of the listing predictor; initial values match the reset state.
	phase_t      walk_phase = PH_IDLE;
	int unsigned walk_pos = 0;
	int unsigned walk_left = 0;
	int unsigned walk_skip = 0;
	int unsigned walk_entries = 0;
	int unsigned walk_last = 0;
	logic [11:0] name_limit = MAX_NAME_LEN_RST;

	reply_word_t  pending_words[$];
	reply_word_t  held_item;
	rdel_result_t expected_verdicts[$];
	int unsigned  mismatch_count = 0;
	int unsigned  words_queued = 0;
	int unsigned  send_idle_pct = 35;
	int unsigned  recv_idle_pct = 83;
	int unsigned  hold_ticket = 0;
	int unsigned  hold_seen = 0;
	int unsigned  hold_left = 0;

	readdir_entry_list_checker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_word    (data_word),
		.first_word   (first_word),
		.total_words  (total_words),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.verdict      (verdict),
		.entry_count  (entry_count),
		.entry_offset (entry_offset),
		.fixup_kind   (fixup_kind),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// End the walk: go idle and report the count and last entry start.
	function automatic rdel_result_t close_walk(input verdict_t v, input fixup_t f);
		rdel_result_t r;
		walk_phase = PH_IDLE;
		r.verdict  = v;
		r.count    = walk_entries[10:0];
		r.offset   = walk_last[9:0];
		r.fixup    = f;
		return r;
	endfunction

	// A length runs past the buffer: keep whole entries if there are any.
	function automatic rdel_result_t close_short();
		if (walk_entries != 0)
			return close_walk(VERDICT_TRUNC, FIX_ZERO_TWO);
		return close_walk(VERDICT_IOERR, FIX_NONE);
	endfunction

	// Advance the listing walk by one accepted word; return 1 when it yields a verdict.
	function automatic bit walk_listing(input reply_word_t item, output rdel_result_t r);
		int unsigned     tot;
		longint unsigned left;
		longint unsigned pad;
		r = '0;
		if (item.first) begin
			// a new buffer always restarts the walk, even mid-entry
			tot = (item.total > MAX_WORDS_DEF) ? MAX_WORDS_DEF : item.total;
			walk_pos     = 0;
			walk_skip    = 0;
			walk_entries = 0;
			walk_last    = 0;
			if (tot < 2) begin
				walk_left = 0;
				r = close_walk(VERDICT_IOERR, FIX_NONE);
				return 1'b1;
			end
			walk_left  = tot - 1;
			walk_phase = PH_VF;
		end else begin
			// drop words outside a walk
			if (walk_phase == PH_IDLE)
				return 1'b0;
			walk_pos++;
			if (walk_left > 0)
				walk_left--;
		end
		// step over cookie, name, bitmap and attribute words
		if (walk_phase != PH_EOF && walk_skip > 0) begin
			walk_skip--;
			return 1'b0;
		end
		left = walk_left;
		// padded word count of a byte length, computed wide so it never wraps
		pad = (64'(item.data) + 64'd3) >> 2;
		case (walk_phase)
			PH_VF: begin
				if (item.data == 0) begin
					if (walk_entries != 0) begin
						r = close_walk(VERDICT_COMPLETE, FIX_NONE);
						return 1'b1;
					end
					walk_phase = PH_EOF;
					return 1'b0;
				end
				if (left < 3) begin
					r = close_short();
					return 1'b1;
				end
				walk_skip  = 2;
				walk_phase = PH_NAME;
			end
			PH_NAME: begin
				if (item.data > name_limit) begin
					r = close_walk(VERDICT_IOERR, FIX_NONE);
					return 1'b1;
				end
				if (left < pad + 1) begin
					r = close_short();
					return 1'b1;
				end
				walk_skip  = 32'(pad);
				walk_phase = PH_BM;
			end
			PH_BM: begin
				if (left < 64'(item.data) + 1) begin
					r = close_short();
					return 1'b1;
				end
				walk_skip  = item.data;
				walk_phase = PH_ATTR;
			end
			PH_ATTR: begin
				if (left < pad + 2) begin
					r = close_short();
					return 1'b1;
				end
				walk_entries = (walk_entries + 1) & 32'h7FF;
				walk_last    = 32'((64'(walk_pos) + 64'd1 + pad) & 64'h3FF);
				walk_skip    = 32'(pad);
				walk_phase   = PH_VF;
			end
			default: begin
				// end-of-list word after an empty list
				r = close_walk(VERDICT_COMPLETE, (item.data == 0) ? FIX_SET_ONE : FIX_NONE);
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic void queue_word(input logic [31:0] data, input logic first,
		input logic [10:0] total);
		reply_word_t item;
		item.data  = data;
		item.first = first;
		item.total = total;
		pending_words.push_back(item);
		words_queued++;
	endfunction

	// Mostly legal name lengths, with the limit itself, one past it, and wild values.
	function automatic logic [31:0] pick_name_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 78)
			return $urandom_range(0, (name_limit < 40) ? name_limit : 40);
		if (roll < 86)
			return {20'b0, name_limit};
		if (roll < 94)
			return name_limit + 1;
		if (roll < 97)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// Build one listing buffer with random content, then maybe damage it.
	// A forced name length gives a single entry with its full name, for big buffers.
	function automatic void queue_listing(input int forced_name);
		logic [31:0]     words[$];
		int unsigned     n_ent, name_bytes, n_bm, attr_bytes, total, keep, roll, idx;
		longint unsigned n_name, n_attr;
		n_ent = (forced_name >= 0) ? 1 : $urandom_range(0, 4);
		for (int e = 0; e < n_ent; e++) begin
			words.push_back(($urandom_range(0, 3) == 0) ? ($urandom | 32'd1) : 32'd1);
			words.push_back($urandom);
			words.push_back($urandom);
			name_bytes = (forced_name >= 0) ? forced_name : pick_name_len();
			n_name = (64'(name_bytes) + 64'd3) >> 2;
			if (forced_name < 0 && n_name > 16)
				n_name = 16;
			words.push_back(name_bytes);
			repeat (n_name) words.push_back($urandom);
			n_bm = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
			words.push_back(n_bm);
			repeat ((n_bm > 3) ? 3 : n_bm) words.push_back($urandom);
			attr_bytes = ($urandom_range(0, 11) == 0) ? $urandom : $urandom_range(0, 48);
			n_attr = (64'(attr_bytes) + 64'd3) >> 2;
			if (n_attr > 12)
				n_attr = 12;
			words.push_back(attr_bytes);
			repeat (n_attr) words.push_back($urandom);
		end
		// value-follows zero, then the end-of-list word
		words.push_back(32'd0);
		words.push_back(($urandom_range(0, 1) == 1) ? 32'd0 : $urandom);

		total = words.size();
		keep  = words.size();
		roll  = $urandom_range(0, 99);
		if (forced_name < 0) begin
			if (roll < 15) begin
				total = $urandom_range(1, words.size());
			end else if (roll < 25) begin
				idx = $urandom_range(0, words.size() - 1);
				words[idx] = $urandom;
			end else if (roll < 35) begin
				// cut short: the next buffer abandons this walk
				keep = $urandom_range(1, words.size());
			end else if (roll < 42) begin
				total = $urandom_range(MAX_WORDS_DEF + 1, 2047);
			end else if (roll < 52) begin
				total = words.size() + $urandom_range(1, 8);
			end
		end
		queue_word(words[0], 1'b1, total[10:0]);
		for (int k = 1; k < keep; k++)
			queue_word(words[k], 1'b0, 11'($urandom_range(0, 2047)));
		// stray words after the buffer
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3))
				queue_word($urandom, 1'b0, 11'($urandom_range(0, 2047)));
	endfunction

	function automatic void queue_random(input int unsigned n_words);
		int unsigned stop;
		stop = words_queued + n_words;
		while (words_queued < stop)
			queue_listing(-1);
	endfunction

	// Wait until every queued word is in and every verdict is out,
	// then let trailing no-result words clear the pipeline.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [11:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		name_limit = value;
	endtask

	// Input side: predict on every accepted item, then offer the next one.
	always @(posedge clk or negedge arst_n) begin
		rdel_result_t due;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (walk_listing(held_item, due))
					expected_verdicts.push_back(due);
			end
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					held_item    = pending_words.pop_front();
					in_valid    <= 1'b1;
					data_word   <= held_item.data;
					first_word  <= held_item.first;
					total_words <= held_item.total;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: compare each verdict with the oldest prediction; drive ready,
	// holding it low for a long stretch whenever a new hold ticket shows up.
	always @(posedge clk or negedge arst_n) begin
		rdel_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected verdict %0d count %0d offset %0d fixup %0d",
							$time, verdict, entry_count, entry_offset, fixup_kind);
				end else begin
					want = expected_verdicts.pop_front();
					if (verdict !== want.verdict || entry_count !== want.count ||
						entry_offset !== want.offset || fixup_kind !== want.fixup) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
								$time, want.verdict, want.count, want.offset, want.fixup,
								verdict, entry_count, entry_offset, fixup_kind);
					end
				end
			end
			if (hold_ticket != hold_seen) begin
				hold_seen <= hold_ticket;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words, name limit at its reset value.
		// stray word before any buffer
		queue_word(32'hFFFF_FFFF, 1'b0, 11'h7FF);
		// buffers too short to hold a listing
		queue_word(32'h0000_0001, 1'b1, 11'd0);
		queue_word(32'h0000_0000, 1'b1, 11'd1);
		// empty list with a zero end word, oversized length gets clamped
		queue_word(32'h0000_0000, 1'b1, 11'h7FF);
		queue_word(32'h0000_0000, 1'b0, 11'd0);
		// empty list with a nonzero end word
		queue_word(32'h0000_0000, 1'b1, 11'd2);
		queue_word(32'hFFFF_FFFF, 1'b0, 11'd0);
		// no room for the cookies
		queue_word(32'h0000_0001, 1'b1, 11'd3);
		// name one byte over the limit
		queue_word(32'hFFFF_FFFF, 1'b1, 11'd10);
		queue_word(32'h0000_0000, 1'b0, 11'd0);
		queue_word(32'hFFFF_FFFF, 1'b0, 11'd0);
		queue_word(32'd256, 1'b0, 11'd0);
		// one whole entry, then the next one runs off the end
		queue_word(32'h0000_0001, 1'b1, 11'd9);
		queue_word(32'h0000_0000, 1'b0, 11'd0);
		queue_word(32'hFFFF_FFFF, 1'b0, 11'd0);
		queue_word(32'd4, 1'b0, 11'd0);
		queue_word(32'hA5A5_5A5A, 1'b0, 11'd0);
		queue_word(32'd0, 1'b0, 11'd0);
		queue_word(32'd0, 1'b0, 11'd0);
		queue_word(32'h0000_0001, 1'b0, 11'd0);
		// attribute length at the top of the range must not wrap
		queue_word(32'h0000_0001, 1'b1, 11'd8);
		queue_word(32'h1234_5678, 1'b0, 11'd0);
		queue_word(32'h8765_4321, 1'b0, 11'd0);
		queue_word(32'd0, 1'b0, 11'd0);
		queue_word(32'd0, 1'b0, 11'd0);
		queue_word(32'hFFFF_FFFF, 1'b0, 11'd0);
		drain();

		// Sender idles lightly, receiver heavily; smallest, then largest limit.
		write_limit(12'd0);
		queue_random(120);
		drain();
		write_limit(12'hFFF);
		queue_listing(4000);
		queue_random(180);
		drain();

		// Swap the idling, random limit.
		send_idle_pct = 83;
		recv_idle_pct = 35;
		write_limit(12'($urandom_range(1, 4094)));
		queue_random(350);
		drain();

		// No idling; small limit so oversized names come often.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_limit(12'($urandom_range(8, 64)));
		queue_random(200);
		drain();

		// Block the receiver, send items that each finish a walk, then random ones, so the block backs up.
		hold_ticket++;
		repeat (24) queue_word($urandom, 1'b1, 11'($urandom_range(0, 1)));
		queue_random(100);
		drain();

		if (mismatch_count == 0 && expected_verdicts.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
